### rtl/core/ecd_pkg.sv
// ----------------------------------------------------------------------------
// ecd_pkg - shared types and constants for the epoch-to-date converter
// Holds the arithmetic constants, the result and configuration structs and
// the month start table used by the conversion pipeline and its wrapper.
// ----------------------------------------------------------------------------
`default_nettype none

package ecd_pkg;

    // Register map (word index on the configuration port).
    localparam logic REG_BASE_YEAR = 1'b0;

    localparam logic [11:0] BASE_YEAR_RESET = 12'd1970;

    // Time constants.
    localparam logic [16:0] DAY_SECS   = 17'd86400;
    localparam logic [16:0] HOUR_SECS  = 17'd3600;
    localparam logic [11:0] MIN_SECS   = 12'd60;
    localparam logic [14:0] CYCLE_DAYS = 15'd1461;
    localparam logic [10:0] YEAR_DAYS  = 11'd365;

    // Reciprocals for exact division by constants. Seconds are divided by
    // 86400 as (t >> 7) / 675, by 3600 as (s >> 4) / 225 and by 60 as
    // (s >> 2) / 15. Each factor is the rounded-up power of two over the
    // divisor, sized so the quotient is exact over the whole input range.
    localparam logic [24:0] DAY_RECIP   = 25'd25451659;  // 2^34 / 675
    localparam int          DAY_SHIFT   = 34;
    localparam logic [13:0] HOUR_RECIP  = 14'd9321;      // 2^21 / 225
    localparam int          HOUR_SHIFT  = 21;
    localparam logic [10:0] MIN_RECIP   = 11'd1093;      // 2^14 / 15
    localparam int          MIN_SHIFT   = 14;
    localparam logic [15:0] CYCLE_RECIP = 16'd45934;     // 2^26 / 1461
    localparam int          CYCLE_SHIFT = 26;

    // Values derived from the base year, used by the second and sixth pipeline stages.
    typedef struct packed {
        logic [12:0] ref_year;   // first year after a leap year, past the base
        logic [10:0] offset;     // days from the base year to the reference year
    } date_cfg_t;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        before_reference;
    } result_t;

    // Day of the year on which a month starts, months counted from 0.
    function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
        logic [8:0] base;
        logic [8:0] adj;
        unique case (idx)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        adj = (leap && (idx >= 4'd2)) ? 9'd1 : 9'd0;
        return base + adj;
    endfunction

endpackage

`default_nettype wire

### rtl/core/ecd_pipe.sv
// ----------------------------------------------------------------------------
// ecd_pipe - seven-stage conversion pipeline
// Splits a seconds count into days and time of day, then into four-year
// cycles, year of cycle, month and day. One word may enter every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ecd_pipe
    import ecd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_vld,
    input  wire logic [30:0] in_secs,
    input  wire date_cfg_t   cfg,
    output logic             out_vld,
    output result_t          out_res
);

    logic [6:0] vld_reg;

    // Stage 1: days by reciprocal multiply.
    logic [48:0] day_prod;
    logic [14:0] s1_days_next, s1_days_reg;
    logic [30:0] s1_secs_reg;

    // Stage 2: seconds of the day, days past the reference year.
    logic [31:0] day_base;
    logic [16:0] s2_sod_next, s2_sod_reg;
    logic [14:0] s2_dd_next, s2_dd_reg;
    logic        s2_bef_next, s2_bef_reg;

    // Stage 3: hour, four-year cycles.
    logic [26:0] hour_prod;
    logic [31:0] cyc_prod;
    logic [4:0]  s3_hour_next, s3_hour_reg;
    logic [4:0]  s3_cyc_next, s3_cyc_reg;
    logic [16:0] s3_sod_reg;
    logic [14:0] s3_dd_reg;
    logic        s3_bef_reg;

    // Stage 4: seconds of the hour, day of the cycle.
    logic [16:0] hour_base;
    logic [14:0] cyc_base;
    logic [11:0] s4_remh_next, s4_remh_reg;
    logic [10:0] s4_dcyc_next, s4_dcyc_reg;
    logic [4:0]  s4_hour_reg;
    logic [4:0]  s4_cyc_reg;
    logic        s4_bef_reg;

    // Stage 5: minute, year of cycle, day of year.
    logic [20:0] min_prod;
    logic [5:0]  s5_min_next, s5_min_reg;
    logic [1:0]  s5_yic_next, s5_yic_reg;
    logic [10:0] doy_wide;
    logic [8:0]  s5_doy_next, s5_doy_reg;
    logic [11:0] s5_remh_reg;
    logic [4:0]  s5_hour_reg;
    logic [4:0]  s5_cyc_reg;
    logic        s5_bef_reg;

    // Stage 6: second, month search, year.
    logic [11:0] min_base;
    logic [5:0]  s6_sec_next, s6_sec_reg;
    logic [3:0]  s6_mon_next, s6_mon_reg;
    logic [11:0] s6_year_next, s6_year_reg;
    logic        s6_leap_next, s6_leap_reg;
    logic [8:0]  s6_doy_reg;
    logic [5:0]  s6_min_reg;
    logic [4:0]  s6_hour_reg;
    logic        s6_bef_reg;

    // Stage 7: day of month and final result.
    logic [8:0]  day_of_year;
    result_t     s7_res_next, s7_res_reg;

    always_comb
    begin
        day_prod     = 49'(in_secs[30:7]) * 49'(DAY_RECIP);
        s1_days_next = day_prod[48:DAY_SHIFT];
    end

    always_comb
    begin
        day_base    = 32'(s1_days_reg) * 32'(DAY_SECS);
        s2_sod_next = 17'(32'(s1_secs_reg) - day_base);
        s2_bef_next = s1_days_reg < 15'(cfg.offset);
        s2_dd_next  = s1_days_reg - 15'(cfg.offset);
    end

    always_comb
    begin
        hour_prod    = 27'(s2_sod_reg[16:4]) * 27'(HOUR_RECIP);
        s3_hour_next = hour_prod[HOUR_SHIFT+4:HOUR_SHIFT];
        cyc_prod     = 32'(s2_dd_reg) * 32'(CYCLE_RECIP);
        s3_cyc_next  = cyc_prod[CYCLE_SHIFT+4:CYCLE_SHIFT];
    end

    always_comb
    begin
        hour_base    = 17'(s3_hour_reg) * HOUR_SECS;
        s4_remh_next = 12'(s3_sod_reg - hour_base);
        cyc_base     = 15'(s3_cyc_reg) * CYCLE_DAYS;
        s4_dcyc_next = 11'(s3_dd_reg - cyc_base);
    end

    always_comb
    begin
        min_prod    = 21'(s4_remh_reg[11:2]) * 21'(MIN_RECIP);
        s5_min_next = min_prod[MIN_SHIFT+5:MIN_SHIFT];
        // The last day of a cycle stays in the fourth year.
        priority if (s4_dcyc_reg >= 11'd1095)
            s5_yic_next = 2'd3;
        else if (s4_dcyc_reg >= 11'd730)
            s5_yic_next = 2'd2;
        else if (s4_dcyc_reg >= YEAR_DAYS)
            s5_yic_next = 2'd1;
        else
            s5_yic_next = 2'd0;
        doy_wide    = s4_dcyc_reg - 11'(s5_yic_next) * YEAR_DAYS;
        s5_doy_next = doy_wide[8:0];
    end

    always_comb
    begin
        min_base     = 12'(s5_min_reg) * MIN_SECS;
        s6_sec_next  = 6'(s5_remh_reg - min_base);
        s6_leap_next = s5_yic_reg == 2'd3;
        // Month index is the number of later month starts already reached.
        s6_mon_next  = 4'd0;
        for (int m = 1; m < 12; m++)
        begin
            if (s5_doy_reg >= month_start(s6_leap_next, 4'(m)))
                s6_mon_next = s6_mon_next + 4'd1;
        end
        s6_year_next = 12'(cfg.ref_year + {6'd0, s5_cyc_reg, 2'b00} + 13'(s5_yic_reg));
    end

    always_comb
    begin
        day_of_year = s6_doy_reg - month_start(s6_leap_reg, s6_mon_reg);
        if (s6_bef_reg)
        begin
            s7_res_next = '0;
            s7_res_next.before_reference = 1'b1;
        end
        else
        begin
            s7_res_next.year             = s6_year_reg;
            s7_res_next.month            = s6_mon_reg + 4'd1;
            s7_res_next.day_of_month     = 5'(day_of_year + 9'd1);
            s7_res_next.hour             = s6_hour_reg;
            s7_res_next.minute           = s6_min_reg;
            s7_res_next.second           = s6_sec_reg;
            s7_res_next.before_reference = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[5:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        s1_days_reg <= s1_days_next;
        s1_secs_reg <= in_secs;

        s2_sod_reg  <= s2_sod_next;
        s2_dd_reg   <= s2_dd_next;
        s2_bef_reg  <= s2_bef_next;

        s3_hour_reg <= s3_hour_next;
        s3_cyc_reg  <= s3_cyc_next;
        s3_sod_reg  <= s2_sod_reg;
        s3_dd_reg   <= s2_dd_reg;
        s3_bef_reg  <= s2_bef_reg;

        s4_remh_reg <= s4_remh_next;
        s4_dcyc_reg <= s4_dcyc_next;
        s4_hour_reg <= s3_hour_reg;
        s4_cyc_reg  <= s3_cyc_reg;
        s4_bef_reg  <= s3_bef_reg;

        s5_min_reg  <= s5_min_next;
        s5_yic_reg  <= s5_yic_next;
        s5_doy_reg  <= s5_doy_next;
        s5_remh_reg <= s4_remh_reg;
        s5_hour_reg <= s4_hour_reg;
        s5_cyc_reg  <= s4_cyc_reg;
        s5_bef_reg  <= s4_bef_reg;

        s6_sec_reg  <= s6_sec_next;
        s6_mon_reg  <= s6_mon_next;
        s6_year_reg <= s6_year_next;
        s6_leap_reg <= s6_leap_next;
        s6_doy_reg  <= s5_doy_reg;
        s6_min_reg  <= s5_min_reg;
        s6_hour_reg <= s5_hour_reg;
        s6_bef_reg  <= s5_bef_reg;

        s7_res_reg  <= s7_res_next;
    end

    assign out_vld = vld_reg[6];
    assign out_res = s7_res_reg;

endmodule

`default_nettype wire

### rtl/core/epoch_seconds_to_calendar_date_core.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_date_core - seconds count to calendar date/time
// Converts whole seconds since 1 January of a programmable base year into
// year, month, day, hour, minute and second, one word per clock cycle.
// ----------------------------------------------------------------------------
// The core accepts a new word on every clock cycle: busy is held low, so a
// word is taken whenever start is high. Each result appears on the result
// ports for one cycle with done high; results leave in the order the words
// came in. The seven register stages of the conversion pipeline lie between
// a word and its result; there is no stall path, and the receiver must take
// every result in the cycle it is shown. The base year lives in one register
// at address 0 of the APB port and should only be changed while no word is
// in flight. Leap years follow the plain every-fourth-year rule. Days are
// counted from a reference year, the first year after a leap year that
// lies past the base year; a count that falls before that year raises
// before_reference and returns all other fields as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_seconds_to_calendar_date_core
    import ecd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    // Command side.
    input  wire logic        start,
    output logic             busy,
    input  wire logic [30:0] seconds_since_base,

    // Result side.
    output logic             done,
    output logic [11:0]      year,
    output logic [3:0]       month,
    output logic [4:0]       day_of_month,
    output logic [4:0]       hour,
    output logic [5:0]       minute,
    output logic [5:0]       second,
    output logic             before_reference
);

    logic [11:0] base_year_reg, base_year_next;
    logic        cfg_wr;
    logic [12:0] ref_year;
    logic [2:0]  ref_gap;
    date_cfg_t   date_cfg;
    logic        accept;
    result_t     res;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // A register write completes in the access phase. Only the word index
    // of the address is decoded.
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        base_year_next = base_year_reg;
        if (cfg_wr && paddr[2] == REG_BASE_YEAR)
            base_year_next = pwdata[11:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            base_year_reg <= BASE_YEAR_RESET;
        else
            base_year_reg <= base_year_next;
    end

    always_comb
    begin
        if (paddr[2] == REG_BASE_YEAR)
            prdata = {20'd0, base_year_reg};
        else
            prdata = '0;
    end

    // The reference year is the next multiple of four at or above the base
    // year, plus one. Exactly one leap day lies between the two, so the day
    // offset is 365 times the year gap plus one.
    always_comb
    begin
        ref_year          = ((13'(base_year_reg) + 13'd3) & ~13'd3) + 13'd1;
        ref_gap           = 3'(ref_year - 13'(base_year_reg));
        date_cfg.ref_year = ref_year;
        date_cfg.offset   = 11'(ref_gap) * YEAR_DAYS + 11'd1;
    end

    ecd_pipe u_pipe
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (accept),
        .in_secs (seconds_since_base),
        .cfg     (date_cfg),
        .out_vld (done),
        .out_res (res)
    );

    assign year             = res.year;
    assign month            = res.month;
    assign day_of_month     = res.day_of_month;
    assign hour             = res.hour;
    assign minute           = res.minute;
    assign second           = res.second;
    assign before_reference = res.before_reference;

    // Every accepted word produces its result after the pipeline latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##7 done)
        else $error("result missing seven cycles after an accepted word");

    // A count before the reference year returns only the flag.
    a_before_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && before_reference) |->
            (year == 12'd0 && month == 4'd0 && day_of_month == 5'd0 &&
             hour == 5'd0 && minute == 6'd0 && second == 6'd0))
        else $error("fields not cleared for a time before the reference year");

    // A converted date always lands on a real month and day.
    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !before_reference) |->
            (month >= 4'd1 && month <= 4'd12 && day_of_month >= 5'd1))
        else $error("month or day out of range");

    // The time-of-day split stays within its bounds.
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59))
        else $error("hour, minute or second out of range");

endmodule

`default_nettype wire

### tb/sv/epoch_seconds_to_calendar_date_core_tb.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_date_core_tb - self-checking bench for the core
// Feeds second counts through the command port under several base years,
// predicts the calendar date of every accepted word and compares each
// strobed result, field by field, in order of arrival.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_seconds_to_calendar_date_core_tb
    import ecd_pkg::*;
();

    // Number of register stages in the core's conversion pipeline.
    localparam int PIPE_DEPTH = 7;
    localparam int WORDS_PER_SEGMENT = 159;
    localparam int SEGMENTS = 9;
    // Largest day number that a 31-bit second count can reach.
    localparam int unsigned LAST_DAY = 24855;
    localparam int unsigned SECS_IN_DAY = 86400;
    localparam int unsigned DAYS_IN_CYCLE = 1461;
    localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    // Byte address of the base year register on the configuration port.
    localparam logic [2:0] BASE_YEAR_ADDR = {REG_BASE_YEAR, 2'b00};

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic [30:0] seconds_since_base;
    logic        done;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        before_reference;

    // Words waiting to be offered, and dates still owed by the core.
    logic [30:0] pending_words[$];
    result_t     expected_dates[$];
    // The bench's own copy of the base year register.
    logic [11:0] base_year_shadow;
    // Chance, in percent, that the driver leaves a cycle empty.
    int unsigned gap_pct;
    // Set at a rising edge when the word on the command port was taken.
    logic        word_taken;
    int          mismatch_count;

    epoch_seconds_to_calendar_date_core dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .start              (start),
        .busy               (busy),
        .seconds_since_base (seconds_since_base),
        .done               (done),
        .year               (year),
        .month              (month),
        .day_of_month       (day_of_month),
        .hour               (hour),
        .minute             (minute),
        .second             (second),
        .before_reference   (before_reference)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Days from 1 January of the base year to 1 January of the reference
    // year. The reference year is the first year after a leap year that lies
    // past the base year, so exactly one leap day falls in between.
    function automatic int unsigned days_to_reference(input logic [11:0] by);
        int unsigned ref_yr;
        ref_yr = ((32'(by) + 3) / 4) * 4 + 1;
        return (ref_yr - 32'(by)) * 365 + 1;
    endfunction

    // Calendar date and time of a second count for a given base year.
    function automatic result_t to_calendar(input logic [30:0] secs, input logic [11:0] by);
        int unsigned day_count;
        int unsigned sod;
        int unsigned ref_yr;
        int unsigned offset;
        int unsigned cycles;
        int unsigned yic;
        int unsigned mon;
        int unsigned mlen;
        int unsigned yr;
        result_t     r;
        day_count = 32'(secs) / SECS_IN_DAY;
        sod = 32'(secs) % SECS_IN_DAY;
        ref_yr = ((32'(by) + 3) / 4) * 4 + 1;
        offset = days_to_reference(by);
        r = '0;
        // Anything before the reference year only raises the flag.
        if (day_count < offset)
        begin
            r.before_reference = 1'b1;
            return r;
        end
        day_count -= offset;
        cycles = day_count / DAYS_IN_CYCLE;
        day_count -= cycles * DAYS_IN_CYCLE;
        // Day 1460 of a cycle still belongs to the fourth, leap, year.
        yic = day_count / 365;
        if (yic > 3)
            yic = 3;
        day_count -= yic * 365;
        mon = 0;
        while (mon < 11)
        begin
            mlen = MONTH_DAYS[mon] + ((yic == 3 && mon == 1) ? 1 : 0);
            if (day_count < mlen)
                break;
            day_count -= mlen;
            mon++;
        end
        yr = ref_yr + 4 * cycles + yic;
        // Years past 4095 simply wrap to the port width.
        r.year = yr[11:0];
        r.month = 4'(mon + 1);
        r.day_of_month = 5'(day_count + 1);
        r.hour = 5'(sod / 3600);
        r.minute = 6'((sod % 3600) / 60);
        r.second = 6'(sod % 60);
        return r;
    endfunction

    // Second count of a given day and second of that day, clipped to 31 bits.
    function automatic logic [30:0] at_day(input int unsigned day, input int unsigned sod);
        longint t;
        t = longint'(day) * SECS_IN_DAY + sod;
        if (t > 64'h7FFF_FFFF)
            t = 64'h7FFF_FFFF;
        return 31'(t);
    endfunction

    // One random second count for the given base year. Many words land on
    // dates that stress the calendar walk: the edge of the reference year,
    // year ends inside a cycle, the leap day and the last day of a cycle.
    function automatic logic [30:0] pick_seconds(input logic [11:0] by);
        int unsigned offset;
        int unsigned kind;
        int unsigned sod;
        int unsigned cyc;
        int unsigned in_cycle;
        int unsigned marks [17];
        marks = '{0, 1, 30, 31, 58, 59, 364, 365, 729, 730, 1094, 1095,
                  1153, 1154, 1155, 1459, 1460};
        offset = days_to_reference(by);
        kind = $urandom_range(9);
        case ($urandom_range(3))
            0:       sod = 0;
            1:       sod = SECS_IN_DAY - 1;
            default: sod = $urandom_range(SECS_IN_DAY - 1);
        endcase
        case (kind)
            0, 1, 2: return 31'($urandom());
            3:       return at_day(offset - $urandom_range(1), sod);
            8:       return 31'($urandom_range(200000));
            9:       return 31'h7FFF_FFFF - 31'($urandom_range(200000));
            default:
            begin
                cyc = $urandom_range((LAST_DAY - offset - DAYS_IN_CYCLE) / DAYS_IN_CYCLE);
                if ($urandom_range(3) == 0)
                    in_cycle = $urandom_range(DAYS_IN_CYCLE - 1);
                else
                    in_cycle = marks[$urandom_range(16)];
                return at_day(offset + cyc * DAYS_IN_CYCLE + in_cycle, sod);
            end
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Writes the base year over the configuration port, then reads it back.
    task automatic program_base_year(input logic [11:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= BASE_YEAR_ADDR;
        pwdata <= {20'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        // Drop straight into the setup cycle of the read-back.
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[11:0] !== value)
            report_mismatch($sformatf("base_year read back %0d, wrote %0d", prdata[11:0], value));
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Waits until every queued word is taken and every date has come back,
    // then lets the pipeline run empty before anything is reconfigured.
    task automatic drain_pipeline();
        int spins;
        spins = 0;
        while (pending_words.size() != 0 || start)
            @(posedge clk);
        while (expected_dates.size() != 0 && spins < 4 * PIPE_DEPTH + 20)
        begin
            @(posedge clk);
            spins++;
        end
        if (expected_dates.size() != 0)
        begin
            report_mismatch($sformatf("%0d dates never came back", expected_dates.size()));
            expected_dates.delete();
        end
        repeat (PIPE_DEPTH + 3) @(posedge clk);
    endtask

    // Command driver. A word stays on the port until it is taken; start is
    // only ever assigned once per falling edge, so back-to-back words keep
    // it high without a glitch.
    always @(negedge clk)
    begin
        if (rst_n && (!start || word_taken))
        begin
            if (pending_words.size() != 0 && $urandom_range(99) >= gap_pct)
            begin
                start <= 1'b1;
                seconds_since_base <= pending_words.pop_front();
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor. It tracks register writes, predicts the date of every word
    // that is taken, and checks every strobed result against the oldest
    // prediction. The receiver cannot stall, so a strobe is always taken.
    always @(posedge clk)
    begin : result_monitor
        result_t want;
        word_taken <= rst_n && start && !busy;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready && paddr == BASE_YEAR_ADDR)
                base_year_shadow = pwdata[11:0];
            if (done)
            begin
                if (expected_dates.size() == 0)
                begin
                    report_mismatch("result strobed with no word outstanding");
                end
                else
                begin
                    want = expected_dates.pop_front();
                    if (year !== want.year)
                        report_mismatch($sformatf("year %0d, want %0d", year, want.year));
                    if (month !== want.month)
                        report_mismatch($sformatf("month %0d, want %0d", month, want.month));
                    if (day_of_month !== want.day_of_month)
                        report_mismatch($sformatf("day_of_month %0d, want %0d",
                                                  day_of_month, want.day_of_month));
                    if (hour !== want.hour)
                        report_mismatch($sformatf("hour %0d, want %0d", hour, want.hour));
                    if (minute !== want.minute)
                        report_mismatch($sformatf("minute %0d, want %0d", minute, want.minute));
                    if (second !== want.second)
                        report_mismatch($sformatf("second %0d, want %0d", second, want.second));
                    if (before_reference !== want.before_reference)
                        report_mismatch($sformatf("before_reference %0b, want %0b",
                                                  before_reference, want.before_reference));
                end
            end
            if (start && !busy)
                expected_dates.push_back(to_calendar(seconds_since_base, base_year_shadow));
        end
    end

    // Stimulus. A directed pass runs first on the reset value of the base
    // year; then each segment programs a new base year and sends random
    // words. The first three segments leave 11 percent of cycles empty, the
    // next three 76 percent, and the last three drive a word every cycle.
    initial
    begin
        logic [11:0] segment_years [SEGMENTS];
        int unsigned ref_off;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start = 1'b0;
        seconds_since_base = '0;
        word_taken = 1'b0;
        base_year_shadow = BASE_YEAR_RESET;
        gap_pct = 11;
        mismatch_count = 0;
        // The extremes of the register (all zeros, all ones) come early so
        // that every bit of it is seen in both states.
        segment_years = '{12'd1901, 12'd2099, 12'd0, 12'hFFF, 12'd2000, 12'd1903,
                          12'($urandom_range(1901, 2099)), 12'($urandom()), 12'd1970};

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed words on the reset base year. They cover the smallest and
        // largest counts, the roll of each time field, the last second before
        // the reference year and its first second, a year end inside a cycle,
        // the leap day, the last day of a cycle and alternating bit patterns.
        ref_off = days_to_reference(BASE_YEAR_RESET);
        pending_words.push_back(31'd0);
        pending_words.push_back(31'd1);
        pending_words.push_back(31'd59);
        pending_words.push_back(31'd60);
        pending_words.push_back(31'd3599);
        pending_words.push_back(31'd3600);
        pending_words.push_back(at_day(0, SECS_IN_DAY - 1));
        pending_words.push_back(at_day(1, 0));
        pending_words.push_back(at_day(ref_off - 1, SECS_IN_DAY - 1));
        pending_words.push_back(at_day(ref_off, 0));
        pending_words.push_back(at_day(ref_off + 364, 43200));
        pending_words.push_back(at_day(ref_off + 365, 1));
        pending_words.push_back(at_day(ref_off + 1095 + 58, 7322));
        pending_words.push_back(at_day(ref_off + 1095 + 59, 50000));
        pending_words.push_back(at_day(ref_off + 1095 + 60, 0));
        pending_words.push_back(at_day(ref_off + 1460, SECS_IN_DAY - 1));
        pending_words.push_back(at_day(ref_off + DAYS_IN_CYCLE, 0));
        pending_words.push_back(31'h7FFF_FFFF);
        pending_words.push_back(31'h5555_5555);
        pending_words.push_back(31'h2AAA_AAAA);
        drain_pipeline();

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg / 3)
                0:       gap_pct = 11;
                1:       gap_pct = 76;
                default: gap_pct = 0;
            endcase
            program_base_year(segment_years[seg]);
            for (int i = 0; i < WORDS_PER_SEGMENT; i++)
                pending_words.push_back(pick_seconds(segment_years[seg]));
            drain_pipeline();
        end

        if (mismatch_count == 0)
            $display("epoch_seconds_to_calendar_date_core verification clean");
        else
            $display("epoch_seconds_to_calendar_date_core verification failed");
        $finish;
    end

    // Watchdog: a run that has not finished in time is reported as failed.
    initial
    begin
        #2000000;
        $display("epoch_seconds_to_calendar_date_core verification failed");
        $finish;
    end

endmodule

`default_nettype wire
